// ===== rtl/core/hcfp_pkg.sv =====
// Package for the header/checksum frame parser.
// Holds the status codes, frame positions, bin codes, the result struct and the class-to-bin map.
// Used by hcfp_frame_acc and header_checksum_frame_parser_core.
`timescale 1ns / 1ps

package hcfp_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_HEADER   = 2'd1,
		ST_LENGTH   = 2'd2,
		ST_CHECKSUM = 2'd3
	} status_t;

	// Byte position counter and the frame layout.
	localparam int unsigned COUNT_W = 4;
	typedef logic [COUNT_W-1:0] pos_t;

	localparam pos_t POS_HDR0     = 4'd0;
	localparam pos_t POS_HDR1     = 4'd1;
	localparam pos_t POS_CLASS    = 4'd2;
	localparam pos_t POS_ANGLE    = 4'd3;
	localparam pos_t POS_X_LO     = 4'd4;
	localparam pos_t POS_X_HI     = 4'd5;
	localparam pos_t POS_Y_LO     = 4'd6;
	localparam pos_t POS_Y_HI     = 4'd7;
	localparam pos_t POS_CHECKSUM = 4'd8;
	localparam pos_t COUNT_MAX    = 4'd15;

	// Header register reset values.
	localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
	localparam logic [7:0] HEADER_SECOND_RST = 8'hBB;

	// Configuration register indexes.
	localparam logic CFG_HEADER_FIRST  = 1'b0;
	localparam logic CFG_HEADER_SECOND = 1'b1;

	// Bin codes.
	localparam logic [1:0] BIN_HAZARDOUS  = 2'd0;
	localparam logic [1:0] BIN_KITCHEN    = 2'd1;
	localparam logic [1:0] BIN_RECYCLABLE = 2'd2;
	localparam logic [1:0] BIN_OTHER      = 2'd3;

	// Outcome of the class lookup: hit is low for classes without a bin.
	typedef struct packed {
		logic       hit;
		logic [1:0] code;
	} bin_lookup_t;

	// One result transaction.
	typedef struct packed {
		status_t     status;
		logic [7:0]  object_class;
		logic [7:0]  angle;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [1:0]  bin;
	} result_t;

	// Maps an object class to its bin.
	function automatic bin_lookup_t bin_of(input logic [7:0] cls);
		bin_lookup_t r;
		r.hit  = 1'b1;
		r.code = BIN_HAZARDOUS;
		case (cls) inside
			8'd0, 8'd1:       r.code = BIN_HAZARDOUS;
			8'd2, 8'd3, 8'd7: r.code = BIN_KITCHEN;
			8'd4, 8'd8:       r.code = BIN_RECYCLABLE;
			8'd5, 8'd6:       r.code = BIN_OTHER;
			default:          r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/hcfp_frame_acc.sv =====
// Per-byte frame state: position counter, running checksum, header flag and captured fields.
// Forms the result for a byte that ends a burst. Depends on hcfp_pkg.
`timescale 1ns / 1ps

module hcfp_frame_acc (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             end_of_frame,
	input  logic [7:0]       header_first,
	input  logic [7:0]       header_second,
	output hcfp_pkg::result_t result
);

	hcfp_pkg::pos_t byte_count_q;
	logic [7:0]     running_sum_q;
	logic           header_ok_q;
	logic [7:0]     class_q;
	logic [7:0]     angle_q;
	logic [15:0]    x_q;
	logic [15:0]    y_q;
	logic [1:0]     last_bin_q;

	hcfp_pkg::bin_lookup_t lookup;
	logic                  header_ok_now;

	// Header comparison against the register values current for this byte.
	always_comb begin
		header_ok_now = header_ok_q;
		if (byte_count_q == hcfp_pkg::POS_HDR0 && data_byte != header_first) begin
			header_ok_now = 1'b0;
		end
		if (byte_count_q == hcfp_pkg::POS_HDR1 && data_byte != header_second) begin
			header_ok_now = 1'b0;
		end
	end

	assign lookup = hcfp_pkg::bin_of(class_q);

	// Result for a byte that ends the burst; checks go length, header, checksum.
	always_comb begin
		result = '0;
		if (byte_count_q != hcfp_pkg::POS_CHECKSUM) begin
			result.status = hcfp_pkg::ST_LENGTH;
		end else if (!header_ok_q) begin
			result.status = hcfp_pkg::ST_HEADER;
		end else if (running_sum_q != data_byte) begin
			result.status = hcfp_pkg::ST_CHECKSUM;
		end else begin
			result.status       = hcfp_pkg::ST_OK;
			result.object_class = class_q;
			result.angle        = angle_q;
			result.x_pos        = x_q;
			result.y_pos        = y_q;
			result.bin          = lookup.hit ? lookup.code : last_bin_q;
		end
	end

	// Burst state: counts, sums and returns to its start at the end of each burst.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			running_sum_q <= '0;
			header_ok_q   <= 1'b1;
			last_bin_q    <= hcfp_pkg::BIN_HAZARDOUS;
		end else if (take) begin
			if (end_of_frame) begin
				byte_count_q  <= '0;
				running_sum_q <= '0;
				header_ok_q   <= 1'b1;
				if (result.status == hcfp_pkg::ST_OK) begin
					last_bin_q <= result.bin;
				end
			end else begin
				header_ok_q <= header_ok_now;
				if (byte_count_q < hcfp_pkg::POS_CHECKSUM) begin
					running_sum_q <= running_sum_q + data_byte;
				end
				if (byte_count_q < hcfp_pkg::COUNT_MAX) begin
					byte_count_q <= byte_count_q + 1'b1;
				end
			end
		end
	end

	// Field capture by position; the last byte of a burst is captured too.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= '0;
			angle_q <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else if (take) begin
			case (byte_count_q)
				hcfp_pkg::POS_CLASS: class_q     <= data_byte;
				hcfp_pkg::POS_ANGLE: angle_q     <= data_byte;
				hcfp_pkg::POS_X_LO:  x_q[7:0]    <= data_byte;
				hcfp_pkg::POS_X_HI:  x_q[15:8]   <= data_byte;
				hcfp_pkg::POS_Y_LO:  y_q[7:0]    <= data_byte;
				hcfp_pkg::POS_Y_HI:  y_q[15:8]   <= data_byte;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/header_checksum_frame_parser_core.sv =====
// Top level of the header/checksum frame parser: configuration registers, handshake and
// output register. Depends on hcfp_pkg and hcfp_frame_acc.
`timescale 1ns / 1ps

// The parser takes one received byte per cycle on the input channel while no last byte is
// stalled, with end_of_frame set on the last byte of a burst. Every byte is handled in the
// cycle it is accepted by the per-byte compare-and-add logic, so the sustained rate is one
// byte per cycle unless a last byte stalls. Only the last byte of a burst produces a result
// transaction: status, the decoded frame fields and the bin code, which are captured in an
// output register when that byte is accepted and held there until taken. Bytes that end no
// burst are accepted even while a result waits; a last byte stalls only while the previous
// result is still held and not being taken in that cycle. The header registers are written
// through cfg_we, cfg_index and cfg_data and take effect at the next byte.
module header_checksum_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  object_class,
	output logic [7:0]  angle,
	output logic [15:0] x_pos,
	output logic [15:0] y_pos,
	output logic [1:0]  bin,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0]        header_first_q;
	logic [7:0]        header_second_q;
	logic              take;
	hcfp_pkg::result_t result;
	hcfp_pkg::result_t result_q;
	logic              out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= hcfp_pkg::HEADER_FIRST_RST;
			header_second_q <= hcfp_pkg::HEADER_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hcfp_pkg::CFG_HEADER_FIRST:  header_first_q  <= cfg_data;
				hcfp_pkg::CFG_HEADER_SECOND: header_second_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A byte that ends a burst needs room in the output register.
	assign in_ready = !end_of_frame || !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	hcfp_frame_acc u_frame_acc (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.data_byte     (data_byte),
		.end_of_frame  (end_of_frame),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.result        (result)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && end_of_frame) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (take && end_of_frame) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = result_q.status;
	assign object_class = result_q.object_class;
	assign angle        = result_q.angle;
	assign x_pos        = result_q.x_pos;
	assign y_pos        = result_q.y_pos;
	assign bin          = result_q.bin;

endmodule
